>>> hdl/box_blur_3x3_zero_border_unit_assert.svh
// ----------------------------------------------------------------------------
// Box blur unit assertion macros
// Shared concurrent assertion forms, clocked on clock and held off in reset.
// ----------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_ZERO_BORDER_UNIT_ASSERT_SVH
`define BOX_BLUR_3X3_ZERO_BORDER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define BBZ_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define BBZ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/bbz_pkg.sv
// ----------------------------------------------------------------------------
// bbz_pkg
// Widths, codes, types and helpers shared by the 3x3 box blur unit.
// ----------------------------------------------------------------------------
package bbz_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   localparam int DIM_W     = 11;
   localparam int PIX_W     = 8;
   localparam int CMD_W     = 1;
   localparam int CSR_IDX_W = 2;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int PEND_W = $clog2(MAX_WIDTH + 2);

   localparam int WIN_COLS = 3;
   localparam int WIN_N    = WIN_COLS * WIN_COLS;
   localparam int SUM_W    = $clog2(WIN_N * 255 + 1);

   // floor(sum / 9) == (sum * 7282) >> 16 for every sum of nine 8-bit pixels
   localparam int                 RECIP_W     = 13;
   localparam logic [RECIP_W-1:0] RECIP_9     = 13'd7282;
   localparam int                 RECIP_SHIFT = 16;

   localparam int MIN_DIM   = 3;
   localparam int RESET_DIM = 16;

   localparam logic [CMD_W-1:0] CMD_PIXEL = 1'b0;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

   typedef logic [WIN_N-1:0][PIX_W-1:0] bbz_win_type;

   // one request as it enters the pipeline
   typedef struct packed {
      logic             is_pixel;
      logic             emit;
      logic             inner;
      logic             frame_end;
      logic [COL_W-1:0] addr;
      logic [PIX_W-1:0] pix;
   } bbz_item_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input int unsigned  maxv);
      logic [DIM_W-1:0] r;
      r = v;
      if (32'(v) < MIN_DIM) r = DIM_W'(MIN_DIM);
      else if (32'(v) > maxv) r = DIM_W'(maxv);
      return r;
   endfunction

endpackage

>>> hdl/bbz_if.sv
// ----------------------------------------------------------------------------
// bbz_req_if / bbz_rsp_if
// Valid/ready channels carrying requests into and results out of the blur unit.
// ----------------------------------------------------------------------------
interface bbz_req_if import bbz_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CMD_W-1:0] cmd;
   logic [PIX_W-1:0] pixel_in;

   modport source (output valid, output cmd, output pixel_in, input ready);
   modport sink   (input valid, input cmd, input pixel_in, output ready);
endinterface

interface bbz_rsp_if import bbz_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_out;
   logic             frame_end;

   modport source (output valid, output pixel_out, output frame_end, input ready);
   modport sink   (input valid, input pixel_out, input frame_end, output ready);
endinterface

>>> hdl/bbz_ram.sv
// ----------------------------------------------------------------------------
// bbz_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bbz_ram #(
   parameter int  WIDTH  = 8,
   parameter int  DEPTH  = 1024,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/bbz_seq.sv
// ----------------------------------------------------------------------------
// bbz_seq
// Image size registers, raster position counters and the owed-output count.
// Decides per request whether it yields a result and where that result lies.
// ----------------------------------------------------------------------------
module bbz_seq import bbz_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_wdata,
   input  logic                 req_accept,
   input  logic [CMD_W-1:0]     req_cmd,
   input  logic [PIX_W-1:0]     req_pixel,
   output bbz_item_type         item
);

   logic [DIM_W-1:0]  w_ff;
   logic [COL_W-1:0]  wm1_ff;
   logic [ROW_W-1:0]  hm1_ff;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [PEND_W-1:0] pend_ff, pend_in;
   logic [COL_W-1:0]  ocol_ff, ocol_in;
   logic [ROW_W-1:0]  orow_ff, orow_in;

   logic [DIM_W-1:0] w_clamp, h_clamp;
   logic             wr_width, wr_height;
   logic             is_pixel, emit;
   logic             col_last, row_last, ocol_last, orow_last;

   assign w_clamp = clamp_dim(csr_wdata, MAX_WIDTH);
   assign h_clamp = clamp_dim(csr_wdata, MAX_HEIGHT);

   always_comb begin
      wr_width  = 1'b0;
      wr_height = 1'b0;
      unique case (csr_index)
         REG_IMAGE_WIDTH:  wr_width  = csr_we;
         REG_IMAGE_HEIGHT: wr_height = csr_we;
         default: ;
      endcase
   end

   assign is_pixel  = (req_cmd == CMD_PIXEL);
   assign col_last  = (col_ff == wm1_ff);
   assign row_last  = (row_ff == hm1_ff);
   assign ocol_last = (ocol_ff == wm1_ff);
   assign orow_last = (orow_ff == hm1_ff);

   // a pixel emits once one row plus one pixel is owed; a flush only at frame start
   assign emit = is_pixel ? (pend_ff > PEND_W'(w_ff))
                          : ((pend_ff != '0) && (col_ff == '0) && (row_ff == '0));

   assign item.is_pixel  = is_pixel;
   assign item.emit      = emit;
   assign item.inner     = is_pixel && (ocol_ff != '0) && !ocol_last &&
                           (orow_ff != '0) && !orow_last;
   assign item.frame_end = ocol_last && orow_last;
   assign item.addr      = col_ff;
   assign item.pix       = req_pixel;

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      pend_in = pend_ff;
      ocol_in = ocol_ff;
      orow_in = orow_ff;
      if (is_pixel) begin
         col_in = col_last ? '0 : col_ff + 1'b1;
         if (col_last) begin
            row_in = row_last ? '0 : row_ff + 1'b1;
         end
         if (!emit) begin
            pend_in = pend_ff + 1'b1;
         end
      end else if (emit) begin
         pend_in = pend_ff - 1'b1;
      end
      if (emit) begin
         ocol_in = ocol_last ? '0 : ocol_ff + 1'b1;
         if (ocol_last) begin
            orow_in = orow_last ? '0 : orow_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff    <= DIM_W'(RESET_DIM);
         wm1_ff  <= COL_W'(RESET_DIM - 1);
         hm1_ff  <= ROW_W'(RESET_DIM - 1);
         col_ff  <= '0;
         row_ff  <= '0;
         pend_ff <= '0;
         ocol_ff <= '0;
         orow_ff <= '0;
      end else begin
         if (wr_width) begin
            w_ff   <= w_clamp;
            wm1_ff <= COL_W'(w_clamp - 1'b1);
         end
         if (wr_height) begin
            hm1_ff <= ROW_W'(h_clamp - 1'b1);
         end
         // a size write starts a new frame and drops owed outputs
         if (wr_width || wr_height) begin
            col_ff  <= '0;
            row_ff  <= '0;
            pend_ff <= '0;
            ocol_ff <= '0;
            orow_ff <= '0;
         end else if (req_accept) begin
            col_ff  <= col_in;
            row_ff  <= row_in;
            pend_ff <= pend_in;
            ocol_ff <= ocol_in;
            orow_ff <= orow_in;
         end
      end
   end

endmodule

>>> hdl/bbz_mean.sv
// ----------------------------------------------------------------------------
// bbz_mean
// Sums the 3x3 window into a register and divides it by nine through a
// reciprocal multiply.
// ----------------------------------------------------------------------------
module bbz_mean import bbz_pkg::*; (
   input  logic             clock,
   input  logic             enable,
   input  bbz_win_type      win,
   output logic [PIX_W-1:0] mean
);

   logic [SUM_W-1:0]         sum_in, sum_ff;
   logic [SUM_W+RECIP_W-1:0] prod;

   always_comb begin
      sum_in = '0;
      for (int k = 0; k < WIN_N; k++) begin
         sum_in = sum_in + SUM_W'(win[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sum_ff <= sum_in;
      end
   end

   assign prod = {{RECIP_W{1'b0}}, sum_ff} * {{SUM_W{1'b0}}, RECIP_9};
   assign mean = prod[RECIP_SHIFT +: PIX_W];

endmodule

>>> hdl/box_blur_3x3_zero_border_unit.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_zero_border_unit
// 3x3 mean filter over a raster stream of 8-bit grey pixels, zero border.
// ----------------------------------------------------------------------------
// Takes one request per clock; each request passes the stage-1, window, sum
// and output registers, and the request port stalls only while the output
// register holds a result not yet taken. One 1024 x 16 simple dual-port line
// store holding the two previous rows paces the pipeline: it is read at column
// c when a pixel request is taken and written back at column c from the
// stage-1 register, so each pixel request needs one read and one write slot.
// Each pixel's result is the output for the pixel image_width + 1 pixels
// earlier; once a whole frame is in, flush requests (cmd = 1) draw out the
// remaining border zeros, the last one marked frame_end. Flushes in mid-frame
// or with nothing owed give no result. A write to either size register
// restarts the frame and drops owed outputs; sizes are clamped to 3..1024.
// ----------------------------------------------------------------------------
module box_blur_3x3_zero_border_unit import bbz_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   bbz_req_if.sink              req_chan,
   bbz_rsp_if.source            rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_wdata
);

   typedef struct packed {
      logic inner;
      logic frame_end;
   } bbz_tag_type;

   logic             advance;
   logic             req_accept;
   bbz_item_type     item;

   logic             s1_valid_ff;
   bbz_item_type     s1_ff;
   logic             s2_emit_ff, s3_emit_ff;
   bbz_tag_type      s2_tag_ff, s3_tag_ff;

   logic [2*PIX_W-1:0] rd_data;
   logic [PIX_W-1:0]   rd_prev2, rd_prev;
   logic               ram_we;

   bbz_win_type      win_ff;
   logic [PIX_W-1:0] mean;

   logic             rsp_valid_ff;
   logic [PIX_W-1:0] rsp_pixel_ff;
   logic             rsp_fend_ff;

   // hold the whole pipeline while a result waits at the output
   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = advance;
   assign req_accept     = req_chan.valid && advance;

   bbz_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_accept (req_accept),
      .req_cmd    (req_chan.cmd),
      .req_pixel  (req_chan.pixel_in),
      .item       (item)
   );

   // line store entry: upper byte two rows back, lower byte previous row
   assign ram_we = advance && s1_valid_ff && s1_ff.is_pixel;

   bbz_ram #(
      .WIDTH (2 * PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (s1_ff.addr),
      .wr_data ({rd_prev, s1_ff.pix}),
      .rd_en   (req_accept),
      .rd_addr (item.addr),
      .rd_data (rd_data)
   );

   assign rd_prev2 = rd_data[2*PIX_W-1:PIX_W];
   assign rd_prev  = rd_data[PIX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_emit_ff  <= 1'b0;
         s3_emit_ff  <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_accept;
         s2_emit_ff  <= s1_valid_ff && s1_ff.emit;
         s3_emit_ff  <= s2_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff               <= item;
         s2_tag_ff.inner     <= s1_ff.inner;
         s2_tag_ff.frame_end <= s1_ff.frame_end;
         s3_tag_ff           <= s2_tag_ff;
      end
   end

   // shift the window left and bring in the new column
   always_ff @(posedge clock) begin
      if (ram_we) begin
         for (int r = 0; r < WIN_COLS; r++) begin
            win_ff[r*WIN_COLS]     <= win_ff[r*WIN_COLS + 1];
            win_ff[r*WIN_COLS + 1] <= win_ff[r*WIN_COLS + 2];
         end
         win_ff[WIN_COLS - 1]       <= rd_prev2;
         win_ff[2*WIN_COLS - 1]     <= rd_prev;
         win_ff[WIN_COLS*WIN_COLS - 1] <= s1_ff.pix;
      end
   end

   bbz_mean u_mean (
      .clock  (clock),
      .enable (advance),
      .win    (win_ff),
      .mean   (mean)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s3_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_pixel_ff <= s3_tag_ff.inner ? mean : '0;
         rsp_fend_ff  <= s3_tag_ff.frame_end;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.pixel_out = rsp_pixel_ff;
   assign rsp_chan.frame_end = rsp_fend_ff;

`include "box_blur_3x3_zero_border_unit_assert.svh"

   `BBZ_ASSERT_SAME(a_stall_blocks_request, rsp_valid_ff && !rsp_chan.ready,
      !req_chan.ready, "request taken while result stalled")

   `BBZ_ASSERT_SAME(a_line_ram_no_collision, ram_we && req_accept && item.is_pixel,
      s1_ff.addr != item.addr, "line store read and write hit the same column")

   `BBZ_ASSERT_NEXT(a_pipe_holds_on_stall, !advance,
      $stable(s1_valid_ff) && $stable(s3_emit_ff), "pipeline moved during stall")

endmodule

>>> test/blur_checker.sv
// ----------------------------------------------------------------------------
// blur_checker
// Watches the request, result and register ports of the 3x3 box blur unit,
// keeps its own copy of the line stores, window and frame position, works out
// the blurred pixel each accepted request releases, and compares each result
// taken from the unit against the oldest owed pixel.
// ----------------------------------------------------------------------------
module blur_checker import bbz_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   bbz_req_if                   req_mon,
   bbz_rsp_if                   rsp_mon,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_wdata,
   output int                   mismatches,
   output int                   results_owed
);

   localparam int PIX_MAX    = (1 << PIX_W) - 1;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             frame_end;
   } blurred_pixel_type;

   logic [PIX_W-1:0]  row_above     [MAX_WIDTH];
   logic [PIX_W-1:0]  row_two_above [MAX_WIDTH];
   logic [PIX_W-1:0]  window_q      [WIN_N];
   logic [DIM_W-1:0]  width_reg;
   logic [DIM_W-1:0]  height_reg;
   int unsigned       col_next;
   int unsigned       row_next;
   int unsigned       owed_count;
   blurred_pixel_type owed_pixels [$];

   function automatic int unsigned dim_in_use(input logic [DIM_W-1:0] raw,
                                              input int unsigned cap);
      if (raw < MIN_DIM) return MIN_DIM;
      if (raw > cap) return cap;
      return raw;
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("[%0t] %s", $time, what);
   endtask

   // Advance the frame state by one request and queue the pixel it releases.
   task automatic blur_request(input logic [CMD_W-1:0] op, input logic [PIX_W-1:0] pix);
      int unsigned       w;
      int unsigned       h;
      int unsigned       total;
      int unsigned       lag;
      int unsigned       col;
      int unsigned       row;
      int unsigned       pos;
      int unsigned       mean;
      blurred_pixel_type due;
      w     = dim_in_use(width_reg, MAX_WIDTH);
      h     = dim_in_use(height_reg, MAX_HEIGHT);
      total = w * h;
      lag   = w + 1;
      col   = (col_next >= w) ? w - 1 : col_next;
      row   = (row_next >= h) ? h - 1 : row_next;

      if (op != CMD_PIXEL) begin
         // honor a flush only on a frame boundary with outputs still owed
         if (owed_count == 0 || col_next != 0 || row_next != 0) return;
         pos = total - owed_count;
         owed_count--;
         due.pixel     = '0;
         due.frame_end = (pos == total - 1);
         owed_pixels.push_back(due);
         return;
      end

      for (int k = 0; k < WIN_COLS; k++) begin
         window_q[k*3]     = window_q[k*3 + 1];
         window_q[k*3 + 1] = window_q[k*3 + 2];
      end
      window_q[2]        = row_two_above[col];
      window_q[5]        = row_above[col];
      window_q[8]        = pix;
      row_two_above[col] = row_above[col];
      row_above[col]     = pix;

      if (owed_count >= lag) begin
         pos = row * w + col + total - lag;
         if (pos >= total) pos -= total;
         due.pixel     = '0;
         due.frame_end = (pos == total - 1);
         if (pos / w != 0 && pos / w != h - 1 && pos % w != 0 && pos % w != w - 1) begin
            mean = 0;
            foreach (window_q[k]) mean += window_q[k];
            mean = mean / WIN_N;
            if (mean > PIX_MAX) mean = PIX_MAX;
            due.pixel = mean[PIX_W-1:0];
         end
         owed_pixels.push_back(due);
      end else begin
         owed_count++;
      end

      col++;
      if (col >= w) begin
         col = 0;
         row++;
         if (row >= h) row = 0;
      end
      col_next = col;
      row_next = row;
   endtask

   always @(posedge clock) begin
      blurred_pixel_type due;
      if (reset) begin
         width_reg  = DIM_W'(RESET_DIM);
         height_reg = DIM_W'(RESET_DIM);
         col_next   = 0;
         row_next   = 0;
         owed_count = 0;
         mismatches = 0;
         foreach (row_above[i]) begin
            row_above[i]     = '0;
            row_two_above[i] = '0;
         end
         foreach (window_q[i]) window_q[i] = '0;
         owed_pixels.delete();
      end else begin
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1)
            blur_request(req_mon.cmd, req_mon.pixel_in);

         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (owed_pixels.size() == 0) begin
               report_mismatch($sformatf("result with nothing owed: pixel %0d frame_end %b",
                                         rsp_mon.pixel_out, rsp_mon.frame_end));
            end else begin
               due = owed_pixels.pop_front();
               if (rsp_mon.pixel_out !== due.pixel)
                  report_mismatch($sformatf("pixel_out %0d, expected %0d",
                                            rsp_mon.pixel_out, due.pixel));
               if (rsp_mon.frame_end !== due.frame_end)
                  report_mismatch($sformatf("frame_end %b, expected %b",
                                            rsp_mon.frame_end, due.frame_end));
            end
         end

         // a size write restarts the frame and drops owed outputs
         if (csr_we === 1'b1) begin
            if (csr_index == REG_IMAGE_WIDTH || csr_index == REG_IMAGE_HEIGHT) begin
               if (csr_index == REG_IMAGE_WIDTH) width_reg = csr_wdata;
               else height_reg = csr_wdata;
               col_next   = 0;
               row_next   = 0;
               owed_count = 0;
            end
         end
      end
      results_owed = owed_pixels.size();
   end

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the 3x3 box blur unit with directed frames, size extremes and
// random frames of random size, with bursty requests and a stalling result
// port; the checker beside the unit predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
   import bbz_pkg::*;

   localparam int IDLE_LIMIT    = 3000;
   localparam int SETTLE_CYCLES = 10;
   localparam int LONG_HOLD     = 120;
   localparam int ITEM_BUDGET   = 950;
   localparam int WIDE_ROW      = MAX_WIDTH / 2;

   localparam logic [CMD_W-1:0]     CMD_FLUSH   = 1'b1;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_B = 2'd3;

   typedef enum {ALWAYS_READY, COIN_FLIP, ONE_IN_FOUR, MOSTLY_READY} stall_style_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DIM_W-1:0]     csr_wdata;
   int                   mismatches;
   int                   results_owed;
   int                   idle_cycles;
   int                   hold_asks;
   int                   burst_left;
   int                   counted;

   bbz_req_if req_bus ();
   bbz_rsp_if rsp_bus ();

   box_blur_3x3_zero_border_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   blur_checker scoreboard (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_bus),
      .rsp_mon      (rsp_bus),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .mismatches   (mismatches),
      .results_owed (results_owed)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Result port: shifting stall styles, plus a long hold-off on request.
   initial begin : receiver
      stall_style_type style;
      int              left;
      int              holds_done;
      int              hold_left;
      rsp_bus.ready = 1'b0;
      style         = ALWAYS_READY;
      left          = 0;
      holds_done    = 0;
      hold_left     = 0;
      forever begin
         @(negedge clock);
         if (holds_done != hold_asks) begin
            holds_done = hold_asks;
            hold_left  = LONG_HOLD;
         end
         if (left == 0) begin
            style = stall_style_type'($urandom_range(0, 3));
            left  = $urandom_range(16, 96);
         end
         left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready = 1'b0;
         end else begin
            case (style)
               ALWAYS_READY: rsp_bus.ready = 1'b1;
               COIN_FLIP:    rsp_bus.ready = 1'($urandom_range(0, 1));
               ONE_IN_FOUR:  rsp_bus.ready = (left % 4 == 0);
               default:      rsp_bus.ready = ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // Offer one request at a falling edge and hold it until taken; valid is
   // left high on return so back-to-back requests never drop it.
   task automatic send_request(input logic [CMD_W-1:0] op, input logic [PIX_W-1:0] pix);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_bus.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_bus.valid    = 1'b1;
      req_bus.cmd      = op;
      req_bus.pixel_in = pix;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      counted++;
      @(negedge clock);
   endtask

   // Drop valid, wait out every owed result, then let the pipeline empty.
   task automatic settle();
      req_bus.valid = 1'b0;
      while (results_owed != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [DIM_W-1:0] value);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we    = 1'b0;
   endtask

   task automatic set_frame(input logic [DIM_W-1:0] w_raw, input logic [DIM_W-1:0] h_raw);
      if ($urandom_range(0, 1) == 1) begin
         write_register(REG_IMAGE_WIDTH, w_raw);
         write_register(REG_IMAGE_HEIGHT, h_raw);
      end else begin
         write_register(REG_IMAGE_HEIGHT, h_raw);
         write_register(REG_IMAGE_WIDTH, w_raw);
      end
   endtask

   // Stream pixels from a frame start; stray flushes land mid-frame only.
   task automatic stream_pixels(input int unsigned n);
      logic [PIX_W-1:0] pix;
      for (int unsigned i = 0; i < n; i++) begin
         if (i > 0 && $urandom_range(0, 29) == 0)
            send_request(CMD_FLUSH, PIX_W'($urandom_range(0, 255)));
         if ($urandom_range(0, 59) == 0) settle();
         case ($urandom_range(0, 7))
            0:       pix = '0;
            1:       pix = '1;
            2:       pix = PIX_W'($urandom_range(240, 255));
            default: pix = PIX_W'($urandom_range(0, 255));
         endcase
         send_request(CMD_PIXEL, pix);
      end
   endtask

   task automatic flush_out(input int unsigned n);
      repeat (n) begin
         send_request(CMD_FLUSH, PIX_W'($urandom_range(0, 255)));
      end
   endtask

   initial begin : stimulus
      int unsigned      w;
      int unsigned      h;
      int unsigned      frames;
      int               phase;
      logic [DIM_W-1:0] w_raw;
      logic [DIM_W-1:0] h_raw;
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.cmd      = CMD_PIXEL;
      req_bus.pixel_in = '0;
      csr_we           = 1'b0;
      csr_index        = REG_IMAGE_WIDTH;
      csr_wdata        = '0;
      hold_asks        = 0;
      burst_left       = 0;
      counted          = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset sizes: nothing owed yet, first result on the eighteenth pixel
      send_request(CMD_FLUSH, '1);
      stream_pixels(18);
      settle();

      // smallest frame: saturated center, mid-frame flush, drain, empty flush
      set_frame(DIM_W'(MIN_DIM), DIM_W'(MIN_DIM));
      send_request(CMD_FLUSH, '0);
      for (int i = 0; i < 9; i++) begin
         send_request(CMD_PIXEL, '1);
         if (i == 3) send_request(CMD_FLUSH, '1);
      end
      flush_out(4);
      send_request(CMD_FLUSH, '0);
      settle();
      // next frame starts before the owed border zeros are flushed
      for (int i = 0; i < 9; i++) send_request(CMD_PIXEL, (i % 2 == 1) ? '1 : '0);
      for (int i = 0; i < 4; i++) send_request(CMD_PIXEL, '0);
      settle();

      // wide rows, tall frames and out-of-range values that clamp
      set_frame(DIM_W'(WIDE_ROW), DIM_W'(MIN_DIM));
      stream_pixels(WIDE_ROW + 6);
      settle();
      set_frame(DIM_W'(MIN_DIM), DIM_W'(MAX_HEIGHT));
      stream_pixels(40);
      settle();
      set_frame('1, DIM_W'(MAX_HEIGHT + 1));
      stream_pixels(24);

      phase = 0;
      while (phase == 0 || counted < ITEM_BUDGET) begin
         settle();
         w = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 20) : $urandom_range(3, 10);
         h = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(3, 8);
         w_raw = DIM_W'(w);
         h_raw = DIM_W'(h);
         if (w == MIN_DIM && $urandom_range(0, 1) == 1) w_raw = DIM_W'($urandom_range(0, 2));
         if (h == MIN_DIM && $urandom_range(0, 1) == 1) h_raw = DIM_W'($urandom_range(0, 2));
         set_frame(w_raw, h_raw);
         if (phase % 6 == 0) hold_asks++;
         frames = $urandom_range(1, 3);
         for (int unsigned f = 0; f < frames; f++) begin
            // a write to an unused index must not restart the frame
            if (f > 0 && $urandom_range(0, 3) == 0) begin
               settle();
               write_register(($urandom_range(0, 1) == 1) ? REG_SPARE_A : REG_SPARE_B,
                              DIM_W'($urandom));
            end
            stream_pixels(w * h);
            if ($urandom_range(0, 3) != 0) begin
               flush_out(w + 1);
               repeat ($urandom_range(0, 2))
                  send_request(CMD_FLUSH, PIX_W'($urandom_range(0, 255)));
            end
         end
         if ($urandom_range(0, 4) == 0) stream_pixels($urandom_range(1, w * h - 1));
         phase++;
      end

      settle();
      if (mismatches == 0 && results_owed == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+hdl
hdl/bbz_pkg.sv
hdl/bbz_if.sv
hdl/bbz_ram.sv
hdl/bbz_seq.sv
hdl/bbz_mean.sv
hdl/box_blur_3x3_zero_border_unit.sv
test/blur_checker.sv
test/testbench.sv
